### rtl/rthsv_pkg.sv
package rthsv_pkg;

	localparam int CH_W        = 8;
	localparam int NUM_W       = 16;
	localparam int DIV_STAGES  = 8;
	localparam int QUO_W       = DIV_STAGES;
	localparam int PREP_STAGES = 2;
	localparam int PIPE_STAGES = PREP_STAGES + DIV_STAGES;
	localparam int ACC_W       = 19;

	localparam int HUE_BASE_GREEN = 120;
	localparam int HUE_BASE_BLUE  = 240;
	localparam int HUE_STEP       = 60;
	localparam int HUE_WRAP       = 360;
	localparam int SAT_SCALE      = 255;
	localparam int HUE_MAX        = 179;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] hue_half_deg;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
	} hsv_t;

	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sector_t;

	typedef struct packed {
		logic [NUM_W-1:0] hue_num;
		logic [NUM_W-1:0] sat_num;
		logic [CH_W-1:0]  chroma;
		logic [CH_W-1:0]  bright;
		logic             grey;
	} prep_t;

	typedef struct packed {
		logic [PREP_STAGES-1:0] adv;
	} prep_ctl_t;

	typedef struct packed {
		logic [DIV_STAGES-1:0] adv;
	} div_ctl_t;

endpackage

### rtl/rthsv_prep.sv
module rthsv_prep (
	input  logic                clk,
	input  rthsv_pkg::prep_ctl_t ctl,
	input  rthsv_pkg::pixel_t   pix,
	output rthsv_pkg::prep_t    prep
);
	import rthsv_pkg::*;

	logic [CH_W-1:0]        mx;
	logic [CH_W-1:0]        mn;
	sector_t                sec;
	logic signed [CH_W:0]   diff;

	logic [CH_W-1:0]        mx_s1;
	logic [CH_W-1:0]        chroma_s1;
	logic signed [CH_W:0]   diff_s1;
	sector_t                sec_s1;

	logic signed [ACC_W-1:0] base_c;
	logic signed [ACC_W-1:0] num_raw;
	logic [ACC_W-1:0]        num_w;

	// Red wins ties over green, green over blue.
	always_comb begin
		mx   = pix.red;
		sec  = SEC_RED;
		diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
		if (!(pix.red >= pix.green && pix.red >= pix.blue)) begin
			if (pix.green >= pix.blue) begin
				mx   = pix.green;
				sec  = SEC_GREEN;
				diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
			end else begin
				mx   = pix.blue;
				sec  = SEC_BLUE;
				diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
			end
		end
		mn = pix.red;
		if (pix.green < mn) begin
			mn = pix.green;
		end
		if (pix.blue < mn) begin
			mn = pix.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			mx_s1     <= mx;
			chroma_s1 <= mx - mn;
			diff_s1   <= diff;
			sec_s1    <= sec;
		end
	end

	always_comb begin
		case (sec_s1)
			SEC_RED:   base_c = '0;
			SEC_GREEN: base_c = ACC_W'(chroma_s1) * ACC_W'(HUE_BASE_GREEN);
			SEC_BLUE:  base_c = ACC_W'(chroma_s1) * ACC_W'(HUE_BASE_BLUE);
			default:   base_c = '0;
		endcase
		num_raw = base_c + ACC_W'(diff_s1) * ACC_W'(HUE_STEP);
		num_w   = num_raw;
		// wrap a negative red-sector angle by a full turn
		if (num_raw[ACC_W-1]) begin
			num_w = num_raw + ACC_W'(chroma_s1) * ACC_W'(HUE_WRAP);
		end
	end

	// Halving the numerator first gives the same floor as dividing by twice chroma.
	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			prep.hue_num <= num_w[NUM_W:1];
			prep.sat_num <= NUM_W'(chroma_s1) * NUM_W'(SAT_SCALE);
			prep.chroma  <= chroma_s1;
			prep.bright  <= mx_s1;
			prep.grey    <= (chroma_s1 == '0);
		end
	end

endmodule

### rtl/rthsv_div.sv
module rthsv_div (
	input  logic                           clk,
	input  rthsv_pkg::div_ctl_t            ctl,
	input  logic [rthsv_pkg::NUM_W-1:0]    num_in,
	input  logic [rthsv_pkg::CH_W-1:0]     den_in,
	output logic [rthsv_pkg::QUO_W-1:0]    quo
);
	import rthsv_pkg::*;

	logic [NUM_W-1:0] rem_s [DIV_STAGES-1];
	logic [CH_W-1:0]  den_s [DIV_STAGES-1];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];

	// Restoring division, one quotient bit per stage, most significant first.
	// Quotient is known to fit QUO_W bits, so the numerator never exceeds den << QUO_W.
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [CH_W-1:0]  den_j;
		logic [QUO_W-1:0] quo_in;
		logic [NUM_W-1:0] trial;
		logic             take;

		if (j == 0) begin : g_first
			assign rem_in = num_in;
			assign den_j  = den_in;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_j  = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		assign trial = NUM_W'(den_j) << (QUO_W-1-j);
		assign take  = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (ctl.adv[j]) begin
				quo_s[j] <= take ? (quo_in | (QUO_W'(1) << (QUO_W-1-j))) : quo_in;
			end
		end

		if (j < DIV_STAGES-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (ctl.adv[j]) begin
					rem_s[j] <= take ? (rem_in - trial) : rem_in;
					den_s[j] <= den_j;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

### rtl/rgb_to_hsv_pixel_core.sv
// Converts one 8-bit BGR pixel to 8-bit HSV: hue in half-degrees (0..179), saturation
// floor(255*chroma/max) and brightness as the largest channel. Grey pixels give hue and
// saturation of 0. One pixel is taken every clock while pix_stall is low. The pipeline has
// ten register stages: two of channel sorting and numerator formation,
// followed by two 8-stage compare-subtract dividers (hue and saturation) that resolve one
// quotient bit per stage.
// Under output stall the pipeline fills its empty stages before pushing back.
module rgb_to_hsv_pixel_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  rthsv_pkg::pixel_t pix,
	output logic              hsv_valid,
	input  logic              hsv_stall,
	output rthsv_pkg::hsv_t   hsv
);
	import rthsv_pkg::*;

	logic [PIPE_STAGES-1:0] valid_s;
	logic [PIPE_STAGES-1:0] adv;

	prep_ctl_t prep_ctl;
	div_ctl_t  div_ctl;
	prep_t     prep;

	logic [QUO_W-1:0] hue_q;
	logic [QUO_W-1:0] sat_q;

	logic [CH_W-1:0] bright_s [DIV_STAGES];
	logic            grey_s   [DIV_STAGES];

	// A stage moves when it is empty or the one after it moves.
	always_comb begin
		adv[PIPE_STAGES-1] = !valid_s[PIPE_STAGES-1] || !hsv_stall;
		for (int k = PIPE_STAGES-2; k >= 0; k--) begin
			adv[k] = !valid_s[k] || adv[k+1];
		end
	end

	assign pix_stall    = !adv[0];
	assign prep_ctl.adv = adv[PREP_STAGES-1:0];
	assign div_ctl.adv  = adv[PIPE_STAGES-1:PREP_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (adv[0]) begin
				valid_s[0] <= pix_valid;
			end
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (adv[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	rthsv_prep u_prep (
		.clk  (clk),
		.ctl  (prep_ctl),
		.pix  (pix),
		.prep (prep)
	);

	rthsv_div u_hue_div (
		.clk    (clk),
		.ctl    (div_ctl),
		.num_in (prep.hue_num),
		.den_in (prep.chroma),
		.quo    (hue_q)
	);

	rthsv_div u_sat_div (
		.clk    (clk),
		.ctl    (div_ctl),
		.num_in (prep.sat_num),
		.den_in (prep.bright),
		.quo    (sat_q)
	);

	// carry brightness and the grey flag alongside the dividers
	always_ff @(posedge clk) begin
		if (div_ctl.adv[0]) begin
			bright_s[0] <= prep.bright;
			grey_s[0]   <= prep.grey;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (div_ctl.adv[k]) begin
				bright_s[k] <= bright_s[k-1];
				grey_s[k]   <= grey_s[k-1];
			end
		end
	end

	// Grey pixels divide by zero in the hue divider (black ones in both): drop their quotients.
	assign hsv_valid        = valid_s[PIPE_STAGES-1];
	assign hsv.hue_half_deg = grey_s[DIV_STAGES-1] ? '0 : hue_q;
	assign hsv.saturation   = grey_s[DIV_STAGES-1] ? '0 : sat_q;
	assign hsv.brightness   = bright_s[DIV_STAGES-1];

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> (hsv.hue_half_deg <= CH_W'(HUE_MAX)))
		else $error("hue beyond half-degree range");

	a_black_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.brightness == '0) |->
			(hsv.saturation == '0 && hsv.hue_half_deg == '0))
		else $error("black pixel with non-zero hue or saturation");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (valid_s == '1 && hsv_stall))
		else $error("input stalled while pipeline has room");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv_stall) |=> (hsv_valid && $stable(hsv)))
		else $error("stalled result beat changed");

endmodule
